// File: rtl/core/atht_pkg.sv
package atht_pkg;

  localparam int TABLE_SLOTS = 1024;
  localparam int SLOT_BITS   = $clog2(TABLE_SLOTS);
  localparam int COUNT_W     = $clog2(TABLE_SLOTS + 1);
  localparam int FULL_W      = COUNT_W + 2;

  localparam int OP_W     = 2;
  localparam int ADDR_W   = 64;
  localparam int SIZE_W   = 40;
  localparam int LIVE_W   = 50;
  localparam int CNT_W    = 32;
  localparam int STATUS_W = 2;
  localparam int ENTRY_W  = 1 + ADDR_W + SIZE_W;

  localparam logic [63:0] MIX_MUL_A = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MIX_MUL_B = 64'hc4ceb9fe1a85ec53;
  localparam int          MIX_SHIFT = 33;

  localparam logic [LIVE_W-1:0] LIVE_MAX  = {LIVE_W{1'b1}};
  localparam logic [FULL_W-1:0] FULL_MARK = FULL_W'(TABLE_SLOTS * 3);

  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_PEAK  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_IGNORED   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNTRACKED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_CLEAR_CUR,
    WR_INSERT,
    WR_MOVE,
    WR_CLEAR_HOLE
  } wr_kind_t;

  typedef enum logic [2:0] {
    FIN_NONE,
    FIN_ALLOC_NEW,
    FIN_ALLOC_OVER,
    FIN_FREE,
    FIN_UNTRACKED,
    FIN_PEAK,
    FIN_IGNORED,
    FIN_FULL
  } fin_kind_t;

  typedef struct packed {
    logic      load;
    logic      hash_start;
    logic      hash_key_sel;
    logic      cur_load_home;
    logic      cur_inc;
    logic      hole_load;
    logic      freed_load;
    wr_kind_t  wr;
    fin_kind_t fin;
  } ctrl_cmd_t;

  typedef struct packed {
    logic hash_done;
    logic slot_valid;
    logic key_match;
    logic table_full;
    logic move_ok;
    logic cur_last;
    logic op_alloc;
    logic op_free;
    logic op_peak;
  } dp_stat_t;

endpackage

// File: rtl/core/atht_ram.sv
module atht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/atht_mix.sv
module atht_mix (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [atht_pkg::ADDR_W-1:0]    key,
  output logic                           done,
  output logic [atht_pkg::SLOT_BITS-1:0] home
);
  import atht_pkg::*;

  logic [63:0] x;
  logic [63:0] acc;
  logic [63:0] prod;
  logic [1:0]  phase;
  logic        round;
  logic        running;
  logic [63:0] mul_c;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [31:0] hi_sum;
  logic [63:0] full;

  assign mul_c  = round ? MIX_MUL_B : MIX_MUL_A;
  assign mul_a  = (phase == 2'd1) ? x[63:32] : x[31:0];
  assign mul_b  = (phase == 2'd2) ? mul_c[63:32] : mul_c[31:0];
  assign hi_sum = acc[63:32] + prod[31:0];
  assign full   = {hi_sum, acc[31:0]};
  assign home   = x[SLOT_BITS-1:0];

  // low 64 bits of x * c from three 32x32 partial products, one per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      phase   <= 2'd0;
      round   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        x       <= key ^ (key >> MIX_SHIFT);
        phase   <= 2'd0;
        round   <= 1'b0;
        running <= 1'b1;
      end else if (running) begin
        phase <= phase + 2'd1;
        case (phase)
          2'd0: prod <= mul_a * mul_b;
          2'd1: begin
            acc  <= prod;
            prod <= mul_a * mul_b;
          end
          2'd2: begin
            acc[63:32] <= hi_sum;
            prod       <= mul_a * mul_b;
          end
          default: begin
            x     <= full ^ (full >> MIX_SHIFT);
            round <= 1'b1;
            if (round) begin
              running <= 1'b0;
              done    <= 1'b1;
            end
          end
        endcase
      end
    end
  end

endmodule

// File: rtl/core/atht_datapath.sv
module atht_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  atht_pkg::ctrl_cmd_t            cmd,
  output atht_pkg::dp_stat_t             stat,
  input  logic [atht_pkg::OP_W-1:0]      opcode,
  input  logic [atht_pkg::ADDR_W-1:0]    address,
  input  logic [atht_pkg::SIZE_W-1:0]    alloc_size,
  output logic                           done,
  output logic [atht_pkg::STATUS_W-1:0]  status,
  output logic [atht_pkg::SIZE_W-1:0]    freed_size,
  output logic [atht_pkg::LIVE_W-1:0]    live_bytes,
  output logic [atht_pkg::LIVE_W-1:0]    peak_bytes,
  output logic [atht_pkg::CNT_W-1:0]     alloc_count,
  output logic [atht_pkg::CNT_W-1:0]     free_count,
  output logic [atht_pkg::CNT_W-1:0]     untracked_count,
  output logic [atht_pkg::COUNT_W-1:0]   entry_count
);
  import atht_pkg::*;

  logic [OP_W-1:0]      op_reg;
  logic [ADDR_W-1:0]    addr_reg;
  logic [SIZE_W-1:0]    size_reg;
  logic [SIZE_W-1:0]    freed;
  logic [SLOT_BITS-1:0] cur;
  logic [SLOT_BITS-1:0] hole;
  logic [COUNT_W-1:0]   occupied;
  logic [LIVE_W-1:0]    live_total;
  logic [LIVE_W-1:0]    peak_total;
  logic [CNT_W-1:0]     allocs_seen;
  logic [CNT_W-1:0]     frees_seen;
  logic [CNT_W-1:0]     unknown_frees;

  logic                 we;
  logic [SLOT_BITS-1:0] waddr;
  logic [ENTRY_W-1:0]   wdata;
  logic [ENTRY_W-1:0]   rdata;
  logic [ADDR_W-1:0]    hash_in;
  logic                 hash_done;
  logic [SLOT_BITS-1:0] home;
  logic [SLOT_BITS-1:0] dh;
  logic [SLOT_BITS-1:0] dk;
  logic [LIVE_W:0]      live_sum;
  logic [LIVE_W-1:0]    live_add;

  atht_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_SLOTS)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(cur),
    .rdata(rdata)
  );

  assign hash_in = cmd.hash_key_sel ? rdata[SIZE_W +: ADDR_W] : addr_reg;

  atht_mix u_mix (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.hash_start),
    .key  (hash_in),
    .done (hash_done),
    .home (home)
  );

  always_comb begin
    we    = 1'b1;
    waddr = cur;
    wdata = '0;
    case (cmd.wr)
      WR_CLEAR_CUR: ;
      WR_INSERT:    wdata = {1'b1, addr_reg, size_reg};
      WR_MOVE: begin
        waddr = hole;
        wdata = rdata;
      end
      WR_CLEAR_HOLE: waddr = hole;
      default: we = 1'b0;
    endcase
  end

  // home cyclically in (hole, cur] keeps the entry in place
  assign dh        = home - hole - SLOT_BITS'(1);
  assign dk        = cur - hole;
  assign live_sum  = {1'b0, live_total} + (LIVE_W + 1)'(size_reg);
  assign live_add  = live_sum[LIVE_W] ? LIVE_MAX : live_sum[LIVE_W-1:0];

  always_comb begin
    stat.hash_done  = hash_done;
    stat.slot_valid = rdata[ENTRY_W-1];
    stat.key_match  = rdata[SIZE_W +: ADDR_W] == addr_reg;
    stat.table_full = ((FULL_W'(occupied) + FULL_W'(1)) << 2) >= FULL_MARK;
    stat.move_ok    = dh >= dk;
    stat.cur_last   = cur == SLOT_BITS'(TABLE_SLOTS - 1);
    stat.op_alloc   = op_reg == OP_ALLOC && addr_reg != '0 && size_reg != '0;
    stat.op_free    = op_reg == OP_FREE && addr_reg != '0;
    stat.op_peak    = op_reg == OP_PEAK;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_reg   <= opcode;
      addr_reg <= address;
      size_reg <= alloc_size;
    end
    if (cmd.freed_load) begin
      freed <= rdata[SIZE_W-1:0];
    end
    if (cmd.hole_load) begin
      hole <= cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur           <= '0;
      occupied      <= '0;
      live_total    <= '0;
      peak_total    <= '0;
      allocs_seen   <= '0;
      frees_seen    <= '0;
      unknown_frees <= '0;
      done          <= 1'b0;
      status        <= ST_OK;
      freed_size    <= '0;
    end else begin
      if (cmd.cur_load_home) begin
        cur <= home;
      end else if (cmd.cur_inc) begin
        cur <= cur + SLOT_BITS'(1);
      end
      done       <= cmd.fin != FIN_NONE;
      freed_size <= '0;
      case (cmd.fin) inside
        FIN_ALLOC_NEW, FIN_ALLOC_OVER: begin
          if (cmd.fin == FIN_ALLOC_NEW) begin
            occupied <= occupied + COUNT_W'(1);
          end
          live_total  <= live_add;
          if (live_add > peak_total) begin
            peak_total <= live_add;
          end
          allocs_seen <= allocs_seen + CNT_W'(1);
          status      <= ST_OK;
        end
        FIN_FREE: begin
          if (occupied != '0) begin
            occupied <= occupied - COUNT_W'(1);
          end
          live_total <= (live_total >= LIVE_W'(freed)) ? live_total - LIVE_W'(freed) : '0;
          frees_seen <= frees_seen + CNT_W'(1);
          freed_size <= freed;
          status     <= ST_OK;
        end
        FIN_UNTRACKED: begin
          unknown_frees <= unknown_frees + CNT_W'(1);
          status        <= ST_UNTRACKED;
        end
        FIN_PEAK: begin
          peak_total <= live_total;
          status     <= ST_OK;
        end
        FIN_IGNORED: status <= ST_IGNORED;
        FIN_FULL:    status <= ST_FULL;
        default: ;
      endcase
    end
  end

  assign live_bytes      = live_total;
  assign peak_bytes      = peak_total;
  assign alloc_count     = allocs_seen;
  assign free_count      = frees_seen;
  assign untracked_count = unknown_frees;
  assign entry_count     = occupied;

endmodule

// File: rtl/core/atht_ctrl.sv
module atht_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  atht_pkg::dp_stat_t  stat,
  output atht_pkg::ctrl_cmd_t cmd
);
  import atht_pkg::*;

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DECODE = 4'd2;
  localparam logic [3:0] S_HASH   = 4'd3;
  localparam logic [3:0] S_PWAIT  = 4'd4;
  localparam logic [3:0] S_PCHK   = 4'd5;
  localparam logic [3:0] S_DWAIT  = 4'd6;
  localparam logic [3:0] S_DCHK   = 4'd7;
  localparam logic [3:0] S_DHASH  = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  assign busy = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '{default: '0, wr: WR_NONE, fin: FIN_NONE};
    unique case (state)
      S_CLEAR: begin
        cmd.wr      = WR_CLEAR_CUR;
        cmd.cur_inc = 1'b1;
        if (stat.cur_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.op_alloc || stat.op_free) begin
          cmd.hash_start = 1'b1;
          state_next     = S_HASH;
        end else begin
          cmd.fin    = stat.op_peak ? FIN_PEAK : FIN_IGNORED;
          state_next = S_IDLE;
        end
      end
      S_HASH: begin
        if (stat.hash_done) begin
          cmd.cur_load_home = 1'b1;
          state_next        = S_PWAIT;
        end
      end
      S_PWAIT: state_next = S_PCHK;
      S_PCHK: begin
        if (!stat.slot_valid) begin
          state_next = S_IDLE;
          if (stat.op_free) begin
            cmd.fin = FIN_UNTRACKED;
          end else if (stat.table_full) begin
            cmd.fin = FIN_FULL;
          end else begin
            cmd.wr  = WR_INSERT;
            cmd.fin = FIN_ALLOC_NEW;
          end
        end else if (stat.key_match) begin
          if (stat.op_free) begin
            cmd.freed_load = 1'b1;
            cmd.hole_load  = 1'b1;
            cmd.cur_inc    = 1'b1;
            state_next     = S_DWAIT;
          end else begin
            cmd.wr     = WR_INSERT;
            cmd.fin    = FIN_ALLOC_OVER;
            state_next = S_IDLE;
          end
        end else begin
          cmd.cur_inc = 1'b1;
          state_next  = S_PWAIT;
        end
      end
      S_DWAIT: state_next = S_DCHK;
      S_DCHK: begin
        if (!stat.slot_valid) begin
          cmd.wr     = WR_CLEAR_HOLE;
          cmd.fin    = FIN_FREE;
          state_next = S_IDLE;
        end else begin
          cmd.hash_start   = 1'b1;
          cmd.hash_key_sel = 1'b1;
          state_next       = S_DHASH;
        end
      end
      S_DHASH: begin
        cmd.hash_key_sel = 1'b1;
        if (stat.hash_done) begin
          if (stat.move_ok) begin
            cmd.wr        = WR_MOVE;
            cmd.hole_load = 1'b1;
          end
          cmd.cur_inc = 1'b1;
          state_next  = S_DWAIT;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule

// File: rtl/core/allocation_tracker_hash_table.sv
// Channel  | Signals                                      | Handshake
// ---------+----------------------------------------------+---------------------------
// command  | opcode, address, alloc_size                  | taken when start && !busy
// result   | status, freed_size, live_bytes, peak_bytes,  | done high for one cycle,
//          | alloc_count, free_count, untracked_count,    | taken at the edge ending it
//          | entry_count                                  |
//
// One item is in flight at a time. A peak reset or an ignored item skips
// the hash. An alloc or free runs the hash and then checks each probed slot;
// a free also rehashes the home of each slot of the cluster behind the removed
// entry, through the one shared mix unit and the single table RAM. After reset
// the table is cleared with busy high. The receiver cannot stall results.
module allocation_tracker_hash_table (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [atht_pkg::OP_W-1:0]      opcode,
  input  logic [atht_pkg::ADDR_W-1:0]    address,
  input  logic [atht_pkg::SIZE_W-1:0]    alloc_size,
  output logic                           done,
  output logic [atht_pkg::STATUS_W-1:0]  status,
  output logic [atht_pkg::SIZE_W-1:0]    freed_size,
  output logic [atht_pkg::LIVE_W-1:0]    live_bytes,
  output logic [atht_pkg::LIVE_W-1:0]    peak_bytes,
  output logic [atht_pkg::CNT_W-1:0]     alloc_count,
  output logic [atht_pkg::CNT_W-1:0]     free_count,
  output logic [atht_pkg::CNT_W-1:0]     untracked_count,
  output logic [atht_pkg::COUNT_W-1:0]   entry_count
);
  import atht_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // sequence probes, inserts and backward-shift deletes
  atht_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .stat (stat),
    .cmd  (cmd)
  );

  // hold the table, the hash unit and the running totals
  atht_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .opcode         (opcode),
    .address        (address),
    .alloc_size     (alloc_size),
    .done           (done),
    .status         (status),
    .freed_size     (freed_size),
    .live_bytes     (live_bytes),
    .peak_bytes     (peak_bytes),
    .alloc_count    (alloc_count),
    .free_count     (free_count),
    .untracked_count(untracked_count),
    .entry_count    (entry_count)
  );

endmodule
